### design/tcp_pkg.sv
// Shared constants, request and status codes, and word types of the CPU time profiler.
`timescale 1ns / 1ps

package tcp_pkg;

    // Slot table size and index width
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    // Field widths
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 32;
    localparam int TIME_W  = 32;
    localparam int PM_W    = 10;
    localparam int NUM_W   = 42;

    // Timestamp forming: seconds shifted up, ticks shifted down
    localparam int STAMP_SHIFT = 11;
    localparam int TICK_SHIFT  = 5;

    // Permille scaling, rounding offset and ceiling
    localparam int PM_SCALE = 1000;
    localparam int PM_HALF  = 500;
    localparam int PM_MAX   = 1000;

    // Request codes
    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_SWITCH = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_QUERY  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [TAG_W-1:0]  thread_tag;
        logic [3:0]        slot_index;
        logic [31:0]       uptime_seconds;
        logic [14:0]       subsecond_ticks;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        slot;
        logic              slot_in_use;
        logic [TAG_W-1:0]  slot_tag;
        logic [CNT_W-1:0]  switches;
        logic [TIME_W-1:0] busy_time;
        logic [PM_W-1:0]   cpu_permille;
    } rsp_word_t;

endpackage

### design/tcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry and register one read entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/tcp_div.sv
// Restoring divider, one quotient bit a cycle, with saturation to the permille ceiling.
`timescale 1ns / 1ps

module tcp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tcp_pkg::NUM_W-1:0] num,
    input  logic [tcp_pkg::TIME_W-1:0] den,
    output logic                      done,
    output logic [tcp_pkg::PM_W-1:0]  permille
);

    import tcp_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;

    logic [TIME_W:0]   rem_shift;
    logic [TIME_W:0]   rem_sub;
    logic              fits;

    // Bring down one numerator bit and try the subtraction
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            num_next    = num;
            den_next    = den;
            rem_next    = '0;
            quo_next    = '0;
        end
        else if (active_reg)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = fits ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            num_reg    <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
        end
    end

    // Clamp the quotient at the ceiling
    assign done     = done_reg;
    assign permille = (quo_reg > NUM_W'(PM_MAX)) ? PM_W'(PM_MAX) : quo_reg[PM_W-1:0];

endmodule

### design/thread_cpu_time_profiler.sv
// Top level of the per-thread CPU time profiler: slot table, request sequencer, result register.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------
//   req     | in        | req_valid, req_stall | tcp_pkg::req_word_t
//   rsp     | out       | rsp_valid, rsp_stall | tcp_pkg::rsp_word_t
//
// One request at a time. Create, remove and switch scan the tag RAM one slot a cycle;
// a miss on the last slot ends the word. A hit reads the slot, updates it and runs the
// divider (42 steps) for the permille. A query skips the scan. Clear and unknown
// requests go straight to the result. Reset empties the table at once through
// per-slot valid bits; no clearing pass. A stalled result holds in the output register
// while the next request is taken; that request finishes only after the result leaves.
`timescale 1ns / 1ps

module thread_cpu_time_profiler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tcp_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tcp_pkg::rsp_word_t rsp
);

    import tcp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACCESS,
        S_UPDATE,
        S_DIVIDE,
        S_FINISH
    } state_t;

    typedef logic [CNT_W+TIME_W-1:0] cnt_entry_t;

    // Low four bits of a slot number
    function automatic logic [3:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+3:0] w;
        w = {4'b0000, s};
        return w[3:0];
    endfunction

    state_t               state_reg, state_next;
    req_word_t            req_reg, req_next;
    rsp_word_t            res_reg, res_next;
    rsp_word_t            rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic [SLOTS-1:0]     tag_valid_reg, tag_valid_next;
    logic [SLOTS-1:0]     cnt_valid_reg, cnt_valid_next;
    logic [TIME_W-1:0]    total_reg, total_next;
    logic [TIME_W-1:0]    prev_reg, prev_next;
    logic                 seen_reg, seen_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SLOT_W:0]      iss_reg, iss_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                 div_start_reg, div_start_next;

    logic                 tag_we;
    logic                 cnt_we;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [TAG_W-1:0]     tag_rdata;
    cnt_entry_t           cnt_rdata;
    cnt_entry_t           cnt_wdata;

    logic [SLOT_W-1:0]    chk_idx;
    logic [TAG_W-1:0]     tag_cur;
    logic [TIME_W-1:0]    busy_cur;
    logic [CNT_W-1:0]     cnt_cur;
    logic [TIME_W-1:0]    stamp;
    logic [TIME_W-1:0]    delta;
    logic [TIME_W-1:0]    busy_new;
    logic [CNT_W-1:0]     cnt_new;
    logic [TIME_W-1:0]    total_new;
    logic [SLOT_W+3:0]    qwide;
    logic                 hit;
    logic [NUM_W-1:0]     div_num;
    logic [TIME_W-1:0]    div_den;
    logic                 div_done;
    logic [PM_W-1:0]      div_permille;

    // Slot tags
    tcp_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (slot_reg),
        .wdata (req_reg.thread_tag),
        .raddr (ram_raddr),
        .rdata (tag_rdata)
    );

    // Slot busy time and switch count
    tcp_ram #(
        .WIDTH (CNT_W + TIME_W),
        .DEPTH (SLOTS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (slot_reg),
        .wdata (cnt_wdata),
        .raddr (ram_raddr),
        .rdata (cnt_rdata)
    );

    tcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .permille (div_permille)
    );

    // Read the scan slot, or the chosen slot once found
    assign ram_raddr = (state_reg == S_ACCESS) ? slot_reg : iss_reg[SLOT_W-1:0];

    // Entries never written read as zero
    assign chk_idx  = (state_reg == S_SCAN) ? pend_idx_reg : slot_reg;
    assign tag_cur  = tag_valid_reg[chk_idx] ? tag_rdata : '0;
    assign busy_cur = cnt_valid_reg[slot_reg] ? cnt_rdata[CNT_W+TIME_W-1:CNT_W] : '0;
    assign cnt_cur  = cnt_valid_reg[slot_reg] ? cnt_rdata[CNT_W-1:0] : '0;

    // Form the switch timestamp and the charged interval
    assign stamp = TIME_W'(req_reg.uptime_seconds << STAMP_SHIFT)
                 | TIME_W'(req_reg.subsecond_ticks >> TICK_SHIFT);
    assign delta     = seen_reg ? (stamp - prev_reg) : TIME_W'(1);
    assign busy_new  = (req_reg.req_type == REQ_SWITCH) ? (busy_cur + delta) : busy_cur;
    assign cnt_new   = (req_reg.req_type == REQ_SWITCH) ? (cnt_cur + 1'b1) : cnt_cur;
    assign total_new = (req_reg.req_type == REQ_SWITCH) ? (total_reg + delta) : total_reg;
    assign cnt_wdata = {busy_new, cnt_new};

    // Scale and round the registered busy time, guard an empty total
    assign div_num = NUM_W'(res_reg.busy_time) * NUM_W'(PM_SCALE) + NUM_W'(PM_HALF);
    assign div_den = (total_reg == '0) ? TIME_W'(1) : total_reg;

    assign qwide = {{SLOT_W{1'b0}}, req.slot_index};

    // Match test for the slot whose tag just came back
    always_comb
    begin
        case (req_reg.req_type)
            REQ_CREATE: hit = !used_reg[pend_idx_reg];
            REQ_REMOVE: hit = (tag_cur == req_reg.thread_tag);
            default:    hit = used_reg[pend_idx_reg] && (tag_cur == req_reg.thread_tag);
        endcase
    end

    // Sequence one request
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        used_next      = used_reg;
        tag_valid_next = tag_valid_reg;
        cnt_valid_next = cnt_valid_reg;
        total_next     = total_reg;
        prev_next      = prev_reg;
        seen_next      = seen_reg;
        slot_next      = slot_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        div_start_next = 1'b0;
        tag_we         = 1'b0;
        cnt_we         = 1'b0;

        // Drop the result once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    unique case (req.req_type) inside
                        REQ_CREATE, REQ_REMOVE, REQ_SWITCH:
                        begin
                            iss_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        REQ_QUERY:
                        begin
                            if (qwide < (SLOT_W + 4)'(SLOTS))
                            begin
                                slot_next  = qwide[SLOT_W-1:0];
                                state_next = S_ACCESS;
                            end
                            else
                            begin
                                res_next.status = ST_NOTFOUND;
                                state_next      = S_FINISH;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cnt_valid_next = '0;
                            total_next     = '0;
                            state_next     = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read
                if (iss_reg < (SLOT_W + 1)'(SLOTS))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = iss_reg[SLOT_W-1:0];
                    iss_next      = iss_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // Check the slot read last cycle
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        slot_next  = pend_idx_reg;
                        pend_next  = 1'b0;
                        state_next = S_ACCESS;
                    end
                    else if (pend_idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        res_next.status = (req_reg.req_type == REQ_CREATE) ? ST_FULL
                                                                            : ST_NOTFOUND;
                        pend_next       = 1'b0;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_ACCESS:
            begin
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                res_next.status      = ST_OK;
                res_next.slot        = slot_out(slot_reg);
                res_next.slot_tag    = tag_cur;
                res_next.slot_in_use = used_reg[slot_reg];
                res_next.switches    = cnt_new;
                res_next.busy_time   = busy_new;
                case (req_reg.req_type)
                    REQ_CREATE:
                    begin
                        tag_we                   = 1'b1;
                        tag_valid_next[slot_reg] = 1'b1;
                        used_next[slot_reg]      = 1'b1;
                        res_next.slot_tag        = req_reg.thread_tag;
                        res_next.slot_in_use     = 1'b1;
                    end
                    REQ_REMOVE:
                    begin
                        used_next[slot_reg]  = 1'b0;
                        res_next.slot_in_use = 1'b0;
                    end
                    REQ_SWITCH:
                    begin
                        cnt_we                   = 1'b1;
                        cnt_valid_next[slot_reg] = 1'b1;
                        total_next               = total_new;
                        prev_next                = stamp;
                        seen_next                = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                // Start the permille division from the updated registers
                div_start_next = 1'b1;
                state_next     = S_DIVIDE;
            end

            S_DIVIDE:
            begin
                if (div_done)
                begin
                    res_next.cpu_permille = div_permille;
                    state_next            = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
            tag_valid_reg <= '0;
            cnt_valid_reg <= '0;
            total_reg     <= '0;
            prev_reg      <= '0;
            seen_reg      <= 1'b0;
            slot_reg      <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
            tag_valid_reg <= tag_valid_next;
            cnt_valid_reg <= cnt_valid_next;
            total_reg     <= total_next;
            prev_reg      <= prev_next;
            seen_reg      <= seen_next;
            slot_reg      <= slot_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            div_start_reg <= div_start_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sim/tb_thread_cpu_time_profiler.sv
// Self-checking testbench for the per-thread CPU time profiler.
`timescale 1ns / 1ps

module tb_thread_cpu_time_profiler;
    import tcp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 100;
    localparam int POOL_SIZE    = 24;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    thread_cpu_time_profiler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Predicted profiler state
    logic [SLOTS-1:0]  slot_used;
    logic [TAG_W-1:0]  slot_tag      [SLOTS];
    logic [TIME_W-1:0] slot_busy     [SLOTS];
    logic [CNT_W-1:0]  slot_switches [SLOTS];
    logic [TIME_W-1:0] total_busy;
    logic [31:0]       last_stamp;
    logic              stamp_valid;

    rsp_word_t expected_rsp[$];
    int        mismatches;
    int        cycle_count;

    // Traffic shaping shared with the receiver process
    int send_idle_pct;
    int rsp_stall_pct;
    int hold_req;
    int hold_left;

    // Random traffic context: tag pool and a running uptime
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];
    logic [31:0]      up_secs;
    logic [14:0]      up_ticks;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Build the report of one slot from the predicted state
    function automatic rsp_word_t slot_report(int s);
        rsp_word_t   r;
        logic [63:0] den;
        logic [63:0] q;
        den = (total_busy == '0) ? 64'd1 : {32'd0, total_busy};
        q   = ({32'd0, slot_busy[s]} * PM_SCALE + PM_HALF) / den;
        r.status       = ST_OK;
        r.slot         = s[3:0];
        r.slot_in_use  = slot_used[s];
        r.slot_tag     = slot_tag[s];
        r.switches     = slot_switches[s];
        r.busy_time    = slot_busy[s];
        r.cpu_permille = (q > PM_MAX) ? PM_W'(PM_MAX) : q[PM_W-1:0];
        return r;
    endfunction

    // Update the predicted table for one request and return its result word
    function automatic rsp_word_t apply_request(req_word_t w);
        rsp_word_t   r;
        logic [31:0] stamp;
        logic [31:0] delta;
        int          hit;
        r   = '0;
        hit = -1;
        case (w.req_type)
            REQ_CREATE:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && !slot_used[s])
                        hit = s;
                if (hit < 0)
                    r.status = ST_FULL;
                else
                begin
                    slot_tag[hit]  = w.thread_tag;
                    slot_used[hit] = 1'b1;
                    r = slot_report(hit);
                end
            end
            REQ_REMOVE:
            begin
                // Stale slots match too
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && slot_tag[s] == w.thread_tag)
                        hit = s;
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    slot_used[hit] = 1'b0;
                    r = slot_report(hit);
                end
            end
            REQ_SWITCH:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && slot_used[s] && slot_tag[s] == w.thread_tag)
                        hit = s;
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    stamp = {w.uptime_seconds[31-STAMP_SHIFT:0], {STAMP_SHIFT{1'b0}}}
                          | {22'd0, w.subsecond_ticks[14:TICK_SHIFT]};
                    delta = stamp_valid ? stamp - last_stamp : 32'd1;
                    last_stamp         = stamp;
                    stamp_valid        = 1'b1;
                    total_busy         = total_busy + delta;
                    slot_busy[hit]     = slot_busy[hit] + delta;
                    slot_switches[hit] = slot_switches[hit] + 32'd1;
                    r = slot_report(hit);
                end
            end
            REQ_CLEAR:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    slot_busy[s]     = '0;
                    slot_switches[s] = '0;
                end
                total_busy = '0;
            end
            REQ_QUERY:
            begin
                r = slot_report(w.slot_index);
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic req_word_t make_word(logic [2:0] code, logic [TAG_W-1:0] tag,
                                            logic [3:0] idx, logic [31:0] secs,
                                            logic [14:0] ticks);
        req_word_t w;
        w.req_type        = code;
        w.thread_tag      = tag;
        w.slot_index      = idx;
        w.uptime_seconds  = secs;
        w.subsecond_ticks = ticks;
        return w;
    endfunction

    // Draw one random request; fill biases toward create over remove
    function automatic req_word_t random_word(bit fill);
        req_word_t   w;
        int          pick;
        int unsigned t;
        pick = $urandom_range(99);
        if (pick < (fill ? 35 : 12))
            w.req_type = REQ_CREATE;
        else if (pick < 45)
            w.req_type = REQ_REMOVE;
        else if (pick < 80)
            w.req_type = REQ_SWITCH;
        else if (pick < 83)
            w.req_type = REQ_CLEAR;
        else if (pick < 95)
            w.req_type = REQ_QUERY;
        else
            w.req_type = 3'($urandom_range(7));
        w.thread_tag = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(POOL_SIZE-1)]
                                                 : TAG_W'($urandom);
        w.slot_index = 4'($urandom_range(15));
        // Advance uptime mostly forward, jump anywhere now and then
        if ($urandom_range(99) < 92)
        begin
            t        = up_ticks + $urandom_range(3000);
            up_secs  = up_secs + 32'(t >> 15) + (($urandom_range(99) < 5) ? 32'd1 : 32'd0);
            up_ticks = 15'(t);
        end
        else
        begin
            up_secs  = $urandom;
            up_ticks = 15'($urandom);
        end
        w.uptime_seconds  = up_secs;
        w.subsecond_ticks = up_ticks;
        return w;
    endfunction

    // Offer one word, hold it until accepted, then record its expected result
    task automatic send_word(req_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp.push_back(apply_request(w));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, or a long hold-off when one is requested
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Compare each result word against the oldest expectation
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", rsp);
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("status",       want.status,       rsp.status);
                check_field("slot",         want.slot,         rsp.slot);
                check_field("slot_in_use",  want.slot_in_use,  rsp.slot_in_use);
                check_field("slot_tag",     want.slot_tag,     rsp.slot_tag);
                check_field("switches",     want.switches,     rsp.switches);
                check_field("busy_time",    want.busy_time,    rsp.busy_time);
                check_field("cpu_permille", want.cpu_permille, rsp.cpu_permille);
            end
        end
    end

    // Corner cases of the table, the timestamp and the share rounding
    task automatic test_directed();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        // Empty total counts as one: a fresh slot rounds to 500
        send_word(make_word(REQ_QUERY,  16'h0000, 4'd15, 32'd0, 15'd0));
        // Never used slot holds tag zero and matches a remove
        send_word(make_word(REQ_REMOVE, 16'h0000, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_SWITCH, 16'h0000, 4'd0, 32'd5, 15'd0));
        send_word(make_word(REQ_CREATE, 16'hFFFF, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_CREATE, 16'h0000, 4'd0, 32'd0, 15'd0));
        // First switch after reset charges one unit
        send_word(make_word(REQ_SWITCH, 16'hFFFF, 4'd0, 32'd0, 15'd0));
        // Busy equals a total of one: share saturates
        send_word(make_word(REQ_QUERY,  16'h0000, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_SWITCH, 16'h0000, 4'd1, 32'hFFFF_FFFF, 15'h7FFF));
        // Stamp goes backward: delta wraps
        send_word(make_word(REQ_SWITCH, 16'hFFFF, 4'd0, 32'd1, 15'd31));
        send_word(make_word(REQ_QUERY,  16'h0000, 4'd1, 32'd0, 15'd0));
        send_word(make_word(REQ_REMOVE, 16'h1234, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_CLEAR,  16'hFFFF, 4'd15, 32'hFFFF_FFFF, 15'h7FFF));
        send_word(make_word(REQ_QUERY,  16'h0000, 4'd0, 32'd0, 15'd0));
        // Unknown request codes
        send_word(make_word(3'd5, 16'hFFFF, 4'd15, 32'hFFFF_FFFF, 15'h7FFF));
        send_word(make_word(3'd6, 16'h0000, 4'd0, 32'd0, 15'd0));
        send_word(make_word(3'd7, 16'hA5A5, 4'd9, 32'h5A5A_5A5A, 15'h2AAA));
        // Free a slot, then switch to it while stale and remove it again
        send_word(make_word(REQ_REMOVE, 16'hFFFF, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_SWITCH, 16'hFFFF, 4'd0, 32'd2, 15'd100));
        send_word(make_word(REQ_REMOVE, 16'hFFFF, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_CREATE, 16'hAAAA, 4'd0, 32'd0, 15'd0));
        send_word(make_word(REQ_SWITCH, 16'hAAAA, 4'd0, 32'd3, 15'd64));
        send_word(make_word(REQ_QUERY,  16'h0000, 4'd0, 32'd0, 15'd0));
    endtask

    // Random traffic under one idling profile
    task automatic test_random_traffic(int count, int idle_pct, int stall_pct, bit fill);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_word(random_word(fill));
    endtask

    // Hold the result side off long enough for the input to back up
    task automatic test_backpressure();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_req      = 400;
        for (int i = 0; i < 16; i++)
            send_word(random_word(1'b1));
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        mismatches    = 0;
        cycle_count   = 0;
        hold_req      = 0;
        hold_left     = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        slot_used     = '0;
        total_busy    = '0;
        last_stamp    = '0;
        stamp_valid   = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_tag[s]      = '0;
            slot_busy[s]     = '0;
            slot_switches[s] = '0;
        end
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            tag_pool[i] = TAG_W'($urandom);
        up_secs  = $urandom_range(1000);
        up_ticks = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(400, 0, 0, 1'b1);
        test_backpressure();
        test_random_traffic(400, 76, 0, 1'b0);
        test_random_traffic(400, 0, 76, 1'b1);
        test_random_traffic(400, 31, 31, 1'b0);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
